// ===== design/hdlcdec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlcdec_pkg
// Shared types, constants and the byte-wise crc-16 step of the hdlc deframer.
// ----------------------------------------------------------------------------
package hdlcdec_pkg;

  localparam logic [7:0]  FlagByte    = 8'h7E;
  localparam logic [7:0]  EscByte     = 8'h7D;
  localparam logic [7:0]  EscFlip     = 8'h20;
  localparam logic [15:0] CrcPoly     = 16'h1021;
  localparam logic [15:0] CrcInit     = 16'h0000;
  localparam logic [2:0]  MinFrameLen = 3'd4;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    KindType   = 2'd0,
    KindMsg    = 2'd1,
    KindStatus = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatCrc   = 2'd1,
    StatShort = 2'd2,
    StatEsc   = 2'd3
  } status_e;

  // one event handed from the front to the back
  typedef struct packed {
    logic       is_close;  // closing flag, else a decoded byte
    logic       bad_esc;   // bad or dangling escape seen in this frame
    logic [7:0] data;
  } evt_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== design/hdlcdec_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlcdec_fifo
// Short event queue between the deframer front and back.
// ----------------------------------------------------------------------------
module hdlcdec_fifo #(
  parameter int unsigned Depth = hdlcdec_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hdlcdec_pkg::evt_t  push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               not_empty_o,
  output hdlcdec_pkg::evt_t  pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  hdlcdec_pkg::evt_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign not_empty_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i & ~full_o;
  assign do_pop      = pop_i & not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/hdlcdec_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlcdec_front
// Flag hunting and escape removal; turns line bytes into queue events.
// ----------------------------------------------------------------------------
module hdlcdec_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic [7:0]         line_byte_i,
  output logic               push_o,
  output hdlcdec_pkg::evt_t  evt_o
);

  logic inside_q, inside_d;
  logic esc_pend_q, esc_pend_d;
  logic esc_err_q, esc_err_d;

  always_comb begin
    inside_d     = inside_q;
    esc_pend_d   = esc_pend_q;
    esc_err_d    = esc_err_q;
    push_o       = 1'b0;
    evt_o.is_close = 1'b0;
    evt_o.bad_esc  = esc_err_q | esc_pend_q;
    evt_o.data     = line_byte_i;
    if (in_fire_i) begin
      if (!inside_q) begin
        if (line_byte_i == hdlcdec_pkg::FlagByte) begin
          inside_d   = 1'b1;
          esc_pend_d = 1'b0;
          esc_err_d  = 1'b0;
        end
      end else if (line_byte_i == hdlcdec_pkg::FlagByte) begin
        push_o         = 1'b1;
        evt_o.is_close = 1'b1;
        inside_d       = 1'b0;
        esc_pend_d     = 1'b0;
        esc_err_d      = 1'b0;
      end else if (esc_err_q) begin
        // drop everything up to the closing flag
      end else if (esc_pend_q) begin
        esc_pend_d = 1'b0;
        if (line_byte_i == (hdlcdec_pkg::FlagByte ^ hdlcdec_pkg::EscFlip)) begin
          push_o     = 1'b1;
          evt_o.data = hdlcdec_pkg::FlagByte;
        end else if (line_byte_i == (hdlcdec_pkg::EscByte ^ hdlcdec_pkg::EscFlip)) begin
          push_o     = 1'b1;
          evt_o.data = hdlcdec_pkg::EscByte;
        end else begin
          esc_err_d = 1'b1;
        end
      end else if (line_byte_i == hdlcdec_pkg::EscByte) begin
        esc_pend_d = 1'b1;
      end else begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q   <= 1'b0;
      esc_pend_q <= 1'b0;
      esc_err_q  <= 1'b0;
    end else begin
      inside_q   <= inside_d;
      esc_pend_q <= esc_pend_d;
      esc_err_q  <= esc_err_d;
    end
  end

endmodule

// ===== design/hdlcdec_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlcdec_back
// CRC, two-byte hold line, length count and the registered result beat.
// ----------------------------------------------------------------------------
module hdlcdec_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               evt_valid_i,
  input  hdlcdec_pkg::evt_t  evt_i,
  output logic               evt_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic [1:0]         item_kind_o,
  output logic [1:0]         frame_status_o,
  output logic               frame_end_o
);

  logic [15:0] crc_q, crc_d;
  logic [7:0]  held0_q, held0_d;
  logic [7:0]  held1_q, held1_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        valid_q, valid_d;

  logic                 res_load;
  logic [7:0]           res_byte;
  hdlcdec_pkg::kind_e   res_kind;
  hdlcdec_pkg::status_e res_stat;
  logic [7:0]           byte_q;
  hdlcdec_pkg::kind_e   kind_q;
  hdlcdec_pkg::status_e stat_q;
  logic                 end_q;

  // the output register frees up in the same cycle it is taken
  assign evt_pop_o = evt_valid_i & (~valid_q | out_ready_i);

  always_comb begin
    crc_d    = crc_q;
    held0_d  = held0_q;
    held1_d  = held1_q;
    cnt_d    = cnt_q;
    res_load = 1'b0;
    res_byte = held0_q;
    res_kind = hdlcdec_pkg::KindMsg;
    res_stat = hdlcdec_pkg::StatOk;
    if (evt_pop_o) begin
      if (evt_i.is_close) begin
        res_load = 1'b1;
        res_byte = 8'h00;
        res_kind = hdlcdec_pkg::KindStatus;
        if (evt_i.bad_esc) begin
          res_stat = hdlcdec_pkg::StatEsc;
        end else if (cnt_q < hdlcdec_pkg::MinFrameLen) begin
          res_stat = hdlcdec_pkg::StatShort;
        end else if (crc_q != 16'h0000) begin
          res_stat = hdlcdec_pkg::StatCrc;
        end
        crc_d   = hdlcdec_pkg::CrcInit;
        held0_d = 8'h00;
        held1_d = 8'h00;
        cnt_d   = '0;
      end else begin
        crc_d = hdlcdec_pkg::crc16_byte(crc_q, evt_i.data);
        if (cnt_q >= 3'd2) begin
          res_load = 1'b1;
          res_kind = (cnt_q == 3'd2) ? hdlcdec_pkg::KindType : hdlcdec_pkg::KindMsg;
        end
        held0_d = held1_q;
        held1_d = evt_i.data;
        if (cnt_q < hdlcdec_pkg::MinFrameLen) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
    valid_d = res_load | (valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= hdlcdec_pkg::CrcInit;
      held0_q <= 8'h00;
      held1_q <= 8'h00;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      crc_q   <= crc_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      byte_q <= res_byte;
      kind_q <= res_kind;
      stat_q <= res_stat;
      end_q  <= (res_kind == hdlcdec_pkg::KindStatus);
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign item_kind_o    = kind_q;
  assign frame_status_o = stat_q;
  assign frame_end_o    = end_q;

endmodule

// ===== design/hdlc_frame_decoder_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlc_frame_decoder_crc16
// HDLC-style byte deframer with escape removal and CRC-16 (0x1021) check.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  in      | in_valid_i / in_ready_o   | line_byte_i
//  out     | out_valid_o / out_ready_i | out_byte_o, item_kind_o, frame_status_o,
//          |                           | frame_end_o
//
// one line byte per cycle sustained while out_ready_i holds; the crc step is
// one byte per cycle in the back. a result passes the queue, then the result
// register, on its way out; a decoded byte itself leaves two decoded bytes later.
// reset clears all framing state; the block hunts for a flag.
// a stalled output fills the event queue; in_ready_o drops only once it is full.
module hdlc_frame_decoder_crc16 #(
  parameter int unsigned QueueDepth = hdlcdec_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] line_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] item_kind_o,
  output logic [1:0] frame_status_o,
  output logic       frame_end_o
);

  logic              q_full, q_not_empty, q_pop, f_push;
  hdlcdec_pkg::evt_t f_evt, q_evt;

  assign in_ready_o = ~q_full;

  hdlcdec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_valid_i & in_ready_o),
    .line_byte_i (line_byte_i),
    .push_o      (f_push),
    .evt_o       (f_evt)
  );

  hdlcdec_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_push),
    .push_data_i (f_evt),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .pop_data_o  (q_evt)
  );

  hdlcdec_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .evt_valid_i    (q_not_empty),
    .evt_i          (q_evt),
    .evt_pop_o      (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .item_kind_o    (item_kind_o),
    .frame_status_o (frame_status_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

// ===== design/hdlcdec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlcdec_checker
// Port-level checks on the deframer input and result channels.
// ----------------------------------------------------------------------------
module hdlcdec_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] line_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] item_kind_o,
  input logic [1:0] frame_status_o,
  input logic       frame_end_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(line_byte_i)))
    else $error("waiting input beat changed");

  a_end_marks_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_end_o == (item_kind_o == hdlcdec_pkg::KindStatus)))
    else $error("frame_end disagrees with item kind");

  a_byte_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_end_o) |-> (frame_status_o == hdlcdec_pkg::StatOk))
    else $error("status nonzero on a byte beat");

  a_status_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> (out_byte_o == 8'h00))
    else $error("data nonzero on a status beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_byte_o)
      && $stable(item_kind_o) && $stable(frame_status_o)))
    else $error("stalled result beat changed");

endmodule

bind hdlc_frame_decoder_crc16 hdlcdec_checker u_checker (.*);
